// ===== rtl/salwct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salwct_pkg
// Shared types and constants of the set-associative LRU write-back tag store.
// ----------------------------------------------------------------------------
package salwct_pkg;

  localparam int MAX_SETS     = 256;
  localparam int MAX_WAYS     = 8;
  localparam int SET_W        = $clog2(MAX_SETS);
  localparam int WAY_W        = 3;
  localparam int RANK_W       = 3;
  localparam int WCNT_W       = WAY_W + 1;
  localparam int ADDR_W       = 32;
  localparam int TAG_W        = 32;
  localparam int OFFB_W       = 5;
  localparam int IDXB_W       = 4;
  localparam int CFG_DATA_W   = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int MAX_IDX_BITS = $clog2(MAX_SETS + 1) - 1;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WAYS = 2'd2;

  localparam logic [OFFB_W-1:0] OFFSET_BITS_RST = 5'd3;
  localparam logic [IDXB_W-1:0] INDEX_BITS_RST  = 4'd4;
  localparam logic [WCNT_W-1:0] ACTIVE_WAYS_RST = 4'd8;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic             writeback;
    logic [WAY_W-1:0] way;
  } rsp_t;

  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rank;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } dp_status_t;

endpackage

// ===== rtl/salwct_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salwct_ctrl
// Two-state sequencer: takes an item, then commits the set update and result.
// ----------------------------------------------------------------------------
module salwct_ctrl
  import salwct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!status.out_blocked) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      ST_LOOKUP: begin
        cmd.commit = !status.out_blocked;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  a_load_leads_lookup: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_LOOKUP)
    else $error("load did not enter lookup");

  a_no_commit_blocked: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !status.out_blocked)
    else $error("commit while result held");

  a_commit_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> state == ST_IDLE)
    else $error("commit did not return to idle");

endmodule

// ===== rtl/salwct_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salwct_dp
// Datapath: config registers, address split, set memory, way compare,
// victim choice, rank update and result register.
// ----------------------------------------------------------------------------
module salwct_dp
  import salwct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  req_t                  req,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp
);

  logic [OFFB_W-1:0] offset_bits;
  logic [IDXB_W-1:0] index_bits;
  logic [WCNT_W-1:0] active_ways;

  logic [IDXB_W-1:0] ib_eff;
  logic [WCNT_W-1:0] ways_eff;
  logic [5:0]        tag_shift;
  logic [SET_W-1:0]  set_mask;
  logic [SET_W-1:0]  set_in;
  logic [TAG_W-1:0]  tag_in;

  logic [SET_W-1:0]  set_q;
  logic [TAG_W-1:0]  tag_q;
  logic              wr_q;

  row_t              mem [MAX_SETS];
  logic [MAX_SETS-1:0] row_ok;
  row_t              rd_row;
  logic              rd_ok;
  row_t              cur;
  row_t              row_w;

  logic [MAX_WAYS-1:0] act;
  logic                hit_f;
  logic [WAY_W-1:0]    hit_way;
  logic                inv_f;
  logic [WAY_W-1:0]    inv_way;
  logic [WAY_W-1:0]    vic_way;
  logic [RANK_W-1:0]   vic_rank;
  logic [WAY_W-1:0]    sel_way;
  logic [RANK_W:0]     old_rank;
  logic                wb;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_BITS_RST;
      index_bits  <= INDEX_BITS_RST;
      active_ways <= ACTIVE_WAYS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_OFFSET_BITS: offset_bits <= cfg_data;
        CFG_INDEX_BITS:  index_bits  <= cfg_data[IDXB_W-1:0];
        CFG_ACTIVE_WAYS: active_ways <= cfg_data[WCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // address split
  always_comb begin
    ib_eff = (index_bits > IDXB_W'(MAX_IDX_BITS)) ? IDXB_W'(MAX_IDX_BITS) : index_bits;
    if (active_ways == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (active_ways > WCNT_W'(MAX_WAYS)) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = active_ways;
    end
    tag_shift = {1'b0, offset_bits} + {2'b00, ib_eff};
    set_mask  = ~({SET_W{1'b1}} << ib_eff);
    set_in    = SET_W'(req.address >> offset_bits) & set_mask;
    tag_in    = (tag_shift >= 6'd32) ? '0 : (req.address >> tag_shift);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      set_q <= set_in;
      tag_q <= tag_in;
      wr_q  <= (req.cmd == CMD_WRITE);
    end
  end

  // set memory, one row per set
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem[set_q] <= row_w;
    end
    if (cmd.load) begin
      rd_row <= mem[set_in];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
      rd_ok  <= 1'b0;
    end else begin
      if (cmd.commit) begin
        row_ok[set_q] <= 1'b1;
      end
      if (cmd.load) begin
        rd_ok <= row_ok[set_in];
      end
    end
  end

  assign cur = rd_ok ? rd_row : '0;

  // lookup and victim choice
  always_comb begin
    hit_f    = 1'b0;
    hit_way  = '0;
    inv_f    = 1'b0;
    inv_way  = '0;
    vic_way  = '0;
    vic_rank = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      act[i] = WCNT_W'(i) < ways_eff;
      if (act[i] && cur[i].valid && cur[i].tag == tag_q && !hit_f) begin
        hit_f   = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (act[i] && !cur[i].valid && !inv_f) begin
        inv_f   = 1'b1;
        inv_way = WAY_W'(i);
      end
      if (i == 0 || (act[i] && cur[i].rank > vic_rank)) begin
        vic_way  = WAY_W'(i);
        vic_rank = cur[i].rank;
      end
    end
  end

  // row update
  always_comb begin
    priority if (hit_f) begin
      sel_way  = hit_way;
      old_rank = {1'b0, cur[hit_way].rank};
    end else if (inv_f) begin
      sel_way  = inv_way;
      old_rank = (RANK_W+1)'(MAX_WAYS);
    end else begin
      sel_way  = vic_way;
      old_rank = {1'b0, vic_rank};
    end
    wb    = !hit_f && !inv_f && cur[vic_way].dirty;
    row_w = cur;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WAY_W'(i) == sel_way) begin
        row_w[i].valid = 1'b1;
        row_w[i].rank  = '0;
        if (hit_f) begin
          row_w[i].dirty = cur[i].dirty | wr_q;
        end else begin
          row_w[i].dirty = wr_q;
          row_w[i].tag   = tag_q;
        end
      end else if (act[i] && cur[i].valid && ({1'b0, cur[i].rank} < old_rank)
                   && (cur[i].rank < RANK_W'(MAX_WAYS - 1))) begin
        row_w[i].rank = cur[i].rank + RANK_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.hit       <= hit_f;
      rsp.writeback <= wb;
      rsp.way       <= sel_way;
    end
  end

  assign status.out_blocked = rsp_valid && rsp_stall;

  a_rsp_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.commit))
    else $error("result appeared without commit");

  a_hit_no_wb: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.hit && rsp.writeback))
    else $error("writeback flagged on a hit");

  a_row_marked: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> row_ok[$past(set_q)])
    else $error("committed set not marked");

endmodule

// ===== rtl/set_assoc_lru_writeback_cache_tags.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_tags
// Tag store of a set-associative, write-allocate, write-back LRU cache.
// ----------------------------------------------------------------------------
// Each access first reads its set row (tags, valid, dirty and LRU ranks of
// all ways) from the set memory, then compares, picks the way, writes the
// updated row back and loads the result register. A new access is
// taken only once the previous one has written its row, so accesses to the
// same set need no forwarding. The result register holds one item; while it
// is stalled the next access waits in its lookup cycle. Sets never written
// since reset read as empty through a per-set valid bit, so there is no
// clearing pass after reset.
module set_assoc_lru_writeback_cache_tags
  import salwct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  salwct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  salwct_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
